### src/navtex_message_framer_unit_assert.svh
// ---------------------------------------------------------------------------
// NAVTEX framer assertion macros
// Shorthand for clocked assertions with synchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef NAVTEX_MESSAGE_FRAMER_UNIT_ASSERT_SVH
`define NAVTEX_MESSAGE_FRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define NAVMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NAVMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/navmf_pkg.sv
// ---------------------------------------------------------------------------
// NAVTEX framer package
// Shared constants and types of the message framer.
// ---------------------------------------------------------------------------
package navmf_pkg;

    localparam int unsigned HDR_LEN  = 11;
    localparam int unsigned END_LEN  = 7;
    localparam int unsigned HIST_LEN = HDR_LEN - 1;
    localparam int unsigned QDEPTH   = HDR_LEN + 1;
    localparam int unsigned CNT_W    = $clog2(QDEPTH + 1);
    localparam int unsigned FRESH_W  = $clog2(HDR_LEN + 1);

    localparam logic [15:0] RST_MAX_CHARS = 16'd4096;

    localparam logic [7:0] CHR_Z  = 8'h5A;
    localparam logic [7:0] CHR_C  = 8'h43;
    localparam logic [7:0] CHR_SP = 8'h20;
    localparam logic [7:0] CHR_CR = 8'h0D;
    localparam logic [7:0] CHR_LF = 8'h0A;
    localparam logic [7:0] CHR_N  = 8'h4E;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       trunc;
    } t_res;

    typedef struct packed {
        logic valid;
        logic burst;
    } t_push;

endpackage

### src/navmf_res_queue.sv
// ---------------------------------------------------------------------------
// NAVTEX framer result queue
// Shift queue of output beats; takes one beat or a whole header burst.
// ---------------------------------------------------------------------------
module navmf_res_queue (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  navmf_pkg::t_push                             i_push,
    input  navmf_pkg::t_res [navmf_pkg::HDR_LEN-1:0]     i_res,
    input  logic                                         i_pop,
    output navmf_pkg::t_res                              o_head,
    output logic                                         o_valid,
    output logic                                         o_room
);

    navmf_pkg::t_res                 r_q [navmf_pkg::QDEPTH];
    navmf_pkg::t_res                 n_q [navmf_pkg::QDEPTH];
    navmf_pkg::t_res                 sh_q [navmf_pkg::QDEPTH];
    logic [navmf_pkg::CNT_W-1:0]     r_cnt;
    logic [navmf_pkg::CNT_W-1:0]     n_cnt;
    logic [navmf_pkg::CNT_W-1:0]     push_n;
    logic                            pop;
    logic                            base_one;

    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= navmf_pkg::CNT_W'(1));
    assign o_head  = r_q[0];
    assign pop     = o_valid && i_pop;
    // push lands behind the one beat that may still be waiting
    assign base_one = r_cnt[0] && !pop;

    always_comb begin
        for (int k = 0; k < navmf_pkg::QDEPTH - 1; k++) begin
            sh_q[k] = r_q[k+1];
        end
        sh_q[navmf_pkg::QDEPTH-1] = r_q[navmf_pkg::QDEPTH-1];

        for (int k = 0; k < navmf_pkg::QDEPTH; k++) begin
            n_q[k] = pop ? sh_q[k] : r_q[k];
        end

        if (i_push.valid) begin
            for (int k = 0; k < navmf_pkg::HDR_LEN; k++) begin
                if (k == 0 || i_push.burst) begin
                    if (base_one) begin
                        n_q[k+1] = i_res[k];
                    end else begin
                        n_q[k] = i_res[k];
                    end
                end
            end
        end

        push_n = '0;
        if (i_push.valid) begin
            push_n = i_push.burst ? navmf_pkg::CNT_W'(navmf_pkg::HDR_LEN)
                                  : navmf_pkg::CNT_W'(1);
        end
        n_cnt = r_cnt - navmf_pkg::CNT_W'(pop) + push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < navmf_pkg::QDEPTH; k++) begin
            r_q[k] <= n_q[k];
        end
    end

endmodule

### src/navtex_message_framer_unit.sv
// ---------------------------------------------------------------------------
// NAVTEX message framer
// Finds ZCZC headers in a character stream and passes framed messages on.
// ---------------------------------------------------------------------------
// Accepted input beats go through the registered result queue.
// Throughput: 1 input beat per cycle in a frame unless output stalls.
// A header match queues an 11-beat burst; input stalls until it drains
// to one waiting beat. Reset (synchronous, active low) clears history,
// frame state and queue; max_chars returns to 4096.
module navtex_message_framer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,    // max_chars
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] in_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,      // [7:0] out_byte
    output logic        o_m_tlast,
    output logic [1:0]  o_m_tuser       // [0] out_first, [1] out_truncated
);

    logic [7:0]                      r_hist [navmf_pkg::HIST_LEN];
    logic                            r_in_frame;
    logic [15:0]                     r_fc;
    logic [navmf_pkg::FRESH_W-1:0]   r_fresh;
    logic [15:0]                     r_max;

    logic [7:0]                      w [navmf_pkg::HDR_LEN];
    logic [navmf_pkg::FRESH_W-1:0]   fresh_inc;
    logic [15:0]                     fc_inc;
    logic                            accept;
    logic                            hdr_hit;
    logic                            hdr_trunc;
    logic                            end_hit;
    logic                            lim_hit;
    logic                            n_in_frame;
    logic [15:0]                     n_fc;
    logic [navmf_pkg::FRESH_W-1:0]   n_fresh;
    navmf_pkg::t_res [navmf_pkg::HDR_LEN-1:0] res;
    navmf_pkg::t_push                push;
    navmf_pkg::t_res                 head;
    logic                            room;

    assign accept     = i_s_tvalid && room;
    assign o_s_tready = room;

    always_comb begin
        for (int k = 0; k < navmf_pkg::HIST_LEN; k++) begin
            w[k] = r_hist[k];
        end
        w[navmf_pkg::HDR_LEN-1] = i_s_tdata;

        fresh_inc = (r_fresh < navmf_pkg::FRESH_W'(navmf_pkg::HDR_LEN))
                    ? r_fresh + navmf_pkg::FRESH_W'(1) : r_fresh;
        fc_inc    = (r_fc != 16'hFFFF) ? r_fc + 16'd1 : r_fc;

        hdr_hit = (fresh_inc == navmf_pkg::FRESH_W'(navmf_pkg::HDR_LEN))
                  && w[0] == navmf_pkg::CHR_Z && w[1] == navmf_pkg::CHR_C
                  && w[2] == navmf_pkg::CHR_Z && w[3] == navmf_pkg::CHR_C
                  && w[4] == navmf_pkg::CHR_SP && w[9] == navmf_pkg::CHR_CR
                  && w[10] == navmf_pkg::CHR_LF;
        hdr_trunc = (r_max <= 16'(navmf_pkg::HDR_LEN));

        // NNNN CR LF LF on the last seven bytes
        end_hit = w[4] == navmf_pkg::CHR_N && w[5] == navmf_pkg::CHR_N
                  && w[6] == navmf_pkg::CHR_N && w[7] == navmf_pkg::CHR_N
                  && w[8] == navmf_pkg::CHR_CR && w[9] == navmf_pkg::CHR_LF
                  && w[10] == navmf_pkg::CHR_LF;
        lim_hit = (fc_inc >= r_max);

        for (int k = 0; k < navmf_pkg::HDR_LEN; k++) begin
            res[k].data  = w[k];
            res[k].first = (k == 0);
            res[k].last  = (k == navmf_pkg::HDR_LEN - 1);
            res[k].trunc = (k == navmf_pkg::HDR_LEN - 1) && hdr_trunc;
        end
        if (r_in_frame) begin
            res[0].data  = i_s_tdata;
            res[0].first = 1'b0;
            res[0].last  = end_hit || lim_hit;
            res[0].trunc = !end_hit && lim_hit;
        end

        push.valid = accept && (r_in_frame || hdr_hit);
        push.burst = !r_in_frame;

        n_in_frame = r_in_frame;
        n_fc       = r_fc;
        n_fresh    = fresh_inc;
        if (!r_in_frame) begin
            if (hdr_hit) begin
                if (hdr_trunc) begin
                    n_fc    = '0;
                    n_fresh = '0;
                end else begin
                    n_in_frame = 1'b1;
                    n_fc       = 16'(navmf_pkg::HDR_LEN);
                end
            end
        end else if (end_hit || lim_hit) begin
            n_in_frame = 1'b0;
            n_fc       = '0;
            n_fresh    = '0;
        end else begin
            n_fc = fc_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < navmf_pkg::HIST_LEN; k++) begin
                r_hist[k] <= '0;
            end
            r_in_frame <= 1'b0;
            r_fc       <= '0;
            r_fresh    <= '0;
            r_max      <= navmf_pkg::RST_MAX_CHARS;
        end else begin
            if (accept) begin
                for (int k = 0; k < navmf_pkg::HIST_LEN; k++) begin
                    r_hist[k] <= w[k+1];
                end
                r_in_frame <= n_in_frame;
                r_fc       <= n_fc;
                r_fresh    <= n_fresh;
            end
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

    navmf_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .i_pop   (i_m_tready),
        .o_head  (head),
        .o_valid (o_m_tvalid),
        .o_room  (room)
    );

    assign o_m_tdata = head.data;
    assign o_m_tlast = head.last;
    assign o_m_tuser = {head.trunc, head.first};

endmodule

### src/navmf_checker.sv
// ---------------------------------------------------------------------------
// NAVTEX framer checker
// Port-level assertions on the output stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "navtex_message_framer_unit_assert.svh"

module navmf_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_m_tready,
    input  logic       o_m_tvalid,
    input  logic [7:0] o_m_tdata,
    input  logic       o_m_tlast,
    input  logic [1:0] o_m_tuser
);

    `NAVMF_ASSERT_NOW(a_trunc_is_last, o_m_tvalid && o_m_tuser[1], o_m_tlast, "truncated beat without tlast")
    `NAVMF_ASSERT_NOW(a_first_not_last, o_m_tvalid && o_m_tuser[0], !o_m_tlast, "header start beat carries tlast")
    // rest of the header burst is queued together with its first beat
    `NAVMF_ASSERT_NEXT(a_burst_continues, o_m_tvalid && o_m_tuser[0] && i_m_tready, o_m_tvalid, "header burst broken")
    `NAVMF_ASSERT_NEXT(a_stall_holds, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stalled beat changed")

endmodule

bind navtex_message_framer_unit navmf_checker u_navmf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tready (i_m_tready),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
